FILE: rtl/core/jse_pkg.sv
// jse_pkg: shared widths, field offsets, codes and the popcount function
// for the jaccard similarity engine; no dependencies

package jse_pkg;

	localparam int DEF_MAX_ITEMS = 64;
	localparam int DEF_MAX_USERS = 1024;
	localparam int DEF_WORD_BITS = 64;

	// input beat fields
	localparam int ITEM_FW   = 6;
	localparam int WIDX_FW   = 4;
	localparam int USER_FW   = 64;
	localparam int A_LSB     = 0;
	localparam int B_LSB     = A_LSB + ITEM_FW;
	localparam int W_LSB     = B_LSB + ITEM_FW;
	localparam int U_LSB     = W_LSB + WIDX_FW;
	localparam int S_TDATA_W = ((U_LSB + USER_FW + 7) / 8) * 8;

	// result beat fields
	localparam int Q_W       = 17;
	localparam int FRAC_W    = 16;
	localparam int OUT_CNT_W = 11;
	localparam int JAC_LSB   = 0;
	localparam int SH_LSB    = JAC_LSB + Q_W;
	localparam int UN_LSB    = SH_LSB + OUT_CNT_W;
	localparam int M_USED_W  = UN_LSB + OUT_CNT_W;
	localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	function automatic logic [6:0] pop64(input logic [63:0] v);
		logic [3:0] bc [8];
		logic [6:0] sum;
		for (int i = 0; i < 8; i++) begin
			bc[i] = '0;
			for (int j = 0; j < 8; j++) begin
				bc[i] = bc[i] + 4'(v[8*i+j]);
			end
		end
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + 7'(bc[i]);
		end
		return sum;
	endfunction

endpackage

FILE: rtl/core/jse_ram.sv
// jse_ram: generic single-write, dual-read synchronous ram with registered reads
// no dependencies

module jse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

FILE: rtl/core/jse_div.sv
// jse_div: radix-2 restoring divider, shared * 2^16 / union, one quotient bit a cycle
// depends on jse_pkg

module jse_div
	import jse_pkg::*;
#(
	parameter int CNT_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [Q_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(Q_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [Q_W-1:0]    bits_q;
	logic [Q_W-1:0]    quo_q;
	logic [CNT_W:0]    trial;
	logic              fits;

	// dividend < 2*divisor, so the quotient fits q_w bits and the high
	// dividend bits collapse into the starting remainder
	assign trial = {rem_q, bits_q[Q_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend >> 1;
			dsr_q  <= divisor;
			bits_q <= {dividend[0], {(Q_W-1){1'b0}}};
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? CNT_W'(trial - {1'b0, dsr_q}) : CNT_W'(trial);
			bits_q <= bits_q << 1;
			quo_q  <= {quo_q[Q_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	assert property (@(posedge clk) disable iff (!arst_n) start |-> divisor != '0)
		else $error("divider started with a zero divisor");

endmodule

FILE: rtl/core/jaccard_similarity_engine_top.sv
// jaccard_similarity_engine_top: item bit-vector store, per-item set-bit counts,
// query sequencer and result register; depends on jse_pkg, jse_ram, jse_div
// load: busy through ST_LWR and ST_LCNT, no result beat; per-item count updated by read-modify-write
// query: accept to result beat runs through the word-pair read loop, the read pipeline drain and,
// unless no division is needed, the 17-step divider
// one item in flight; the next item is taken while a result beat waits downstream
// reset: clearing pass over all MAX_ITEMS * WPI bit-store words (1024 at defaults), no input taken

module jaccard_similarity_engine_top
	import jse_pkg::*;
#(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS,
	parameter int MAX_USERS = DEF_MAX_USERS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// item_a, item_b, word_index, user_bits
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// action
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// jaccard_q16, shared_count, union_count, zero pad
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	localparam int WPI       = (MAX_USERS + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH     = MAX_ITEMS * WPI;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int ITEM_W    = $clog2(MAX_ITEMS);
	localparam int WIDX_W    = (WPI > 1) ? $clog2(WPI) : 1;
	localparam int CNT_W     = $clog2(MAX_USERS + 1);
	localparam int LAST_BITS = MAX_USERS - (WPI - 1) * WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_LWR   = 8'b0000_0100,
		ST_LCNT  = 8'b0000_1000,
		ST_QRD   = 8'b0001_0000,
		ST_QWAIT = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	function automatic logic [ADDR_W-1:0] word_addr(input logic [ITEM_W-1:0] item,
		input logic [WIDX_W-1:0] wi);
		return ADDR_W'(item * WPI + wi);
	endfunction

	state_t state_q, state_d;

	logic [ITEM_FW-1:0]   in_a, in_b;
	logic [WIDX_FW-1:0]   in_w;
	logic [USER_FW-1:0]   in_user;
	logic [WORD_BITS-1:0] in_word;
	logic                 accept, load_ok;

	logic [ADDR_W-1:0]    clr_q;
	logic [WIDX_W-1:0]    k_q;
	logic                 rd_vld_s1, rd_vld_s2, cnt_vld_s1;
	logic                 m_valid_q;

	logic [ITEM_FW-1:0]   a_q, b_q;
	logic                 va_q, vb_q;
	logic [WIDX_W-1:0]    widx_q;
	logic [WORD_BITS-1:0] nv_q;
	logic [6:0]           pco_q, pcn_q;
	logic [CNT_W-1:0]     oldcnt_q;
	logic [6:0]           pc_s2;
	logic [CNT_W-1:0]     shared_q, ca_q, cb_q, uni;
	logic [Q_W-1:0]       jac_q;
	logic [Q_W-1:0]       out_jac_q;
	logic [OUT_CNT_W-1:0] out_sh_q, out_un_q;

	logic                 bit_we;
	logic [ADDR_W-1:0]    bit_waddr, bit_raddr0, bit_raddr1;
	logic [WORD_BITS-1:0] bit_wdata, bit_rdata0, bit_rdata1;
	logic                 cnt_we;
	logic [ITEM_W-1:0]    cnt_waddr, cnt_raddr0, cnt_raddr1;
	logic [CNT_W-1:0]     cnt_wdata, cnt_rdata0, cnt_rdata1;

	logic                 div_start, div_done, out_load, query_hit;
	logic [Q_W-1:0]       div_quo;

	assign in_a    = s_axis_tdata[A_LSB +: ITEM_FW];
	assign in_b    = s_axis_tdata[B_LSB +: ITEM_FW];
	assign in_w    = s_axis_tdata[W_LSB +: WIDX_FW];
	assign in_user = s_axis_tdata[U_LSB +: USER_FW];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign load_ok       = (32'(in_a) < 32'(MAX_ITEMS)) && (32'(in_w) < 32'(WPI));
	// users past the last one are dropped from the final word
	assign in_word = (32'(in_w) == 32'(WPI - 1)) ?
		(in_user[WORD_BITS-1:0] & LAST_MASK) : in_user[WORD_BITS-1:0];

	assign uni       = ca_q + cb_q - shared_q;
	assign query_hit = (shared_q != '0) && (a_q != b_q) && (uni != '0);
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// bit store ports
	assign bit_raddr0 = (state_q == ST_IDLE) ?
		word_addr(ITEM_W'(in_a), WIDX_W'(in_w)) : word_addr(ITEM_W'(a_q), k_q);
	assign bit_raddr1 = word_addr(ITEM_W'(b_q), k_q);
	assign bit_we     = (state_q == ST_CLR) || (state_q == ST_LWR);
	assign bit_waddr  = (state_q == ST_CLR) ? clr_q : word_addr(ITEM_W'(a_q), widx_q);
	assign bit_wdata  = (state_q == ST_CLR) ? '0 : nv_q;

	// count store ports
	assign cnt_raddr0 = (state_q == ST_IDLE) ? ITEM_W'(in_a) : ITEM_W'(a_q);
	assign cnt_raddr1 = ITEM_W'(b_q);
	assign cnt_we     = ((state_q == ST_CLR) && (32'(clr_q) < 32'(MAX_ITEMS))) ||
		(state_q == ST_LCNT);
	assign cnt_waddr  = (state_q == ST_CLR) ? ITEM_W'(clr_q) : ITEM_W'(a_q);
	assign cnt_wdata  = (state_q == ST_CLR) ? '0 :
		CNT_W'(oldcnt_q - CNT_W'(pco_q) + CNT_W'(pcn_q));

	jse_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_bit_ram (
		.clk   (clk),
		.we    (bit_we),
		.waddr (bit_waddr),
		.wdata (bit_wdata),
		.raddr0(bit_raddr0),
		.raddr1(bit_raddr1),
		.rdata0(bit_rdata0),
		.rdata1(bit_rdata1)
	);

	jse_ram #(
		.WIDTH(CNT_W),
		.DEPTH(MAX_ITEMS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr0(cnt_raddr0),
		.raddr1(cnt_raddr1),
		.rdata0(cnt_rdata0),
		.rdata1(cnt_rdata1)
	);

	jse_div #(
		.CNT_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(shared_q),
		.divisor (uni),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_CLR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == ACT_QUERY) begin
						state_d = ST_QRD;
					end else if (load_ok) begin
						state_d = ST_LWR;
					end
				end
			end
			ST_LWR: begin
				state_d = ST_LCNT;
			end
			ST_LCNT: begin
				state_d = ST_IDLE;
			end
			ST_QRD: begin
				if (k_q == WIDX_W'(WPI - 1)) begin
					state_d = ST_QWAIT;
				end
			end
			ST_QWAIT: begin
				if (!rd_vld_s1 && !rd_vld_s2) begin
					if (query_hit) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			k_q        <= '0;
			rd_vld_s1  <= 1'b0;
			rd_vld_s2  <= 1'b0;
			cnt_vld_s1 <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= (state_q == ST_QRD);
			rd_vld_s2  <= rd_vld_s1;
			cnt_vld_s1 <= (state_q == ST_QRD) && (k_q == '0);
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_QRD) begin
				k_q <= k_q + 1'b1;
			end else begin
				k_q <= '0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= in_a;
			b_q    <= in_b;
			va_q   <= 32'(in_a) < 32'(MAX_ITEMS);
			vb_q   <= 32'(in_b) < 32'(MAX_ITEMS);
			widx_q <= WIDX_W'(in_w);
			nv_q   <= in_word;
		end
		// load: old word and old count arrive in the cycle after accept
		if (state_q == ST_LWR) begin
			pco_q    <= pop64(64'(bit_rdata0));
			pcn_q    <= pop64(64'(nv_q));
			oldcnt_q <= cnt_rdata0;
		end
		// query: shared bits of each word pair, two-stage count and sum
		pc_s2 <= pop64(64'(bit_rdata0 & bit_rdata1));
		if (accept) begin
			shared_q <= '0;
		end else if (rd_vld_s2 && va_q && vb_q) begin
			shared_q <= shared_q + CNT_W'(pc_s2);
		end
		if (cnt_vld_s1) begin
			ca_q <= va_q ? cnt_rdata0 : '0;
			cb_q <= vb_q ? cnt_rdata1 : '0;
		end
		if (state_q == ST_QWAIT) begin
			jac_q <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			jac_q <= div_quo;
		end
		if (out_load) begin
			out_jac_q <= jac_q;
			out_sh_q  <= OUT_CNT_W'(shared_q);
			out_un_q  <= OUT_CNT_W'(uni);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_un_q, out_sh_q, out_jac_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QRD || state_q == ST_QWAIT || state_q == ST_DIV) |-> !bit_we)
		else $error("bit store written during a query");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (shared_q != '0 && uni != '0 && a_q != b_q))
		else $error("division started for a zero or same-item result");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_jac_q <= Q_ONE))
		else $error("similarity above one");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

endmodule

FILE: dv/jaccard_similarity_engine_top_tb.sv
`timescale 1ns / 100ps
// jaccard_similarity_engine_top_tb: self-checking bench for the jaccard similarity engine,
// predicts each query's shared, union and q1.16 similarity from its own copy of the item vectors
// depends on jse_pkg and jaccard_similarity_engine_top

module jaccard_similarity_engine_top_tb
	import jse_pkg::*;
;

	localparam int ITEMS       = DEF_MAX_ITEMS;
	localparam int WORDS       = DEF_MAX_USERS / DEF_WORD_BITS;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [Q_W-1:0]       jaccard;
		logic [OUT_CNT_W-1:0] both_cnt;
		logic [OUT_CNT_W-1:0] either_cnt;
	} score_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	logic [63:0]          vec_words [ITEMS][WORDS];
	logic [OUT_CNT_W-1:0] vec_ones [ITEMS];
	score_t               pending_scores [$];

	int unsigned cycle_cnt = 0;
	int unsigned mismatches = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;

	jaccard_similarity_engine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: always ready, coin flip, or mostly stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 200);
		end
		stall_left = stall_left - 1;
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// model of the item vectors and counts
	function automatic void apply_load(input logic [5:0] item, input logic [3:0] widx,
			input logic [63:0] bits);
		vec_ones[item] = vec_ones[item] - OUT_CNT_W'($countones(vec_words[item][widx]))
			+ OUT_CNT_W'($countones(bits));
		vec_words[item][widx] = bits;
	endfunction

	function automatic score_t score_pair(input logic [5:0] a, input logic [5:0] b);
		score_t s;
		int     both;
		int     either;
		longint q;
		both = 0;
		for (int k = 0; k < WORDS; k++) begin
			both += $countones(vec_words[a][k] & vec_words[b][k]);
		end
		either = int'(vec_ones[a]) + int'(vec_ones[b]) - both;
		q = 0;
		if (both > 0 && a != b && either != 0) begin
			q = (longint'(both) << FRAC_W) / either;
		end
		s.jaccard    = Q_W'(q);
		s.both_cnt   = OUT_CNT_W'(both);
		s.either_cnt = OUT_CNT_W'(either);
		return s;
	endfunction

	always @(posedge clk) begin
		score_t got;
		score_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.jaccard    = m_axis_tdata[JAC_LSB +: Q_W];
			got.both_cnt   = m_axis_tdata[SH_LSB +: OUT_CNT_W];
			got.either_cnt = m_axis_tdata[UN_LSB +: OUT_CNT_W];
			if (pending_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: jaccard %0d shared %0d union %0d",
						got.jaccard, got.both_cnt, got.either_cnt);
			end else begin
				want = pending_scores.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: jaccard %0d/%0d shared %0d/%0d union %0d/%0d (exp/act)",
							want.jaccard, got.jaccard, want.both_cnt, got.both_cnt,
							want.either_cnt, got.either_cnt);
				end
			end
		end
	end

	task automatic send_item(input action_t act, input logic [5:0] a, input logic [5:0] b,
			input logic [3:0] widx, input logic [63:0] bits);
		logic [S_TDATA_W-1:0] data;
		int                   gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 12);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		data = '0;
		data[A_LSB +: ITEM_FW] = a;
		data[B_LSB +: ITEM_FW] = b;
		data[W_LSB +: WIDX_FW] = widx;
		data[U_LSB +: USER_FW] = bits;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		if (act == ACT_LOAD)
			apply_load(a, widx, bits);
		else
			pending_scores.push_back(score_pair(a, b));
		burst_left--;
	endtask

	task automatic wait_all_scores();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return r & {$urandom, $urandom} & {$urandom, $urandom};
			3: return r | {$urandom, $urandom};
			4: return 64'h1 << $urandom_range(0, 63);
			default: return r;
		endcase
	endfunction

	task automatic test_special_cases();
		send_item(ACT_QUERY, 6'd0, 6'd63, 4'd0, '0);
		send_item(ACT_QUERY, 6'd9, 6'd9, 4'd15, '1);
		send_item(ACT_LOAD, 6'd0, 6'd0, 4'd0, '1);
		send_item(ACT_LOAD, 6'd63, 6'd63, 4'd15, '1);
		send_item(ACT_QUERY, 6'd0, 6'd63, 4'd0, '0);
		send_item(ACT_LOAD, 6'd63, 6'd0, 4'd0, 64'h1);
		send_item(ACT_QUERY, 6'd63, 6'd0, 4'd0, '0);
		send_item(ACT_QUERY, 6'd0, 6'd0, 4'd0, '0);
		send_item(ACT_LOAD, 6'd1, 6'd21, 4'd0, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(ACT_LOAD, 6'd1, 6'd42, 4'd15, 64'h5555_5555_5555_5555);
		send_item(ACT_QUERY, 6'd0, 6'd1, 4'd5, 64'h5555_5555_5555_5555);
		send_item(ACT_LOAD, 6'd0, 6'd0, 4'd0, '0);
		send_item(ACT_QUERY, 6'd0, 6'd1, 4'd10, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(ACT_LOAD, 6'd2, 6'd0, 4'd3, 64'h8000_0000_0000_0001);
		send_item(ACT_LOAD, 6'd3, 6'd0, 4'd3, 64'h8000_0000_0000_0001);
		send_item(ACT_QUERY, 6'd2, 6'd3, 4'd0, '0);
		send_item(ACT_QUERY, 6'd3, 6'd1, 4'd0, '0);
	endtask

	// two items full, so shared and union reach the whole user range
	task automatic test_full_vectors();
		for (int k = 0; k < WORDS; k++) begin
			send_item(ACT_LOAD, 6'd62, 6'($urandom), 4'(k), '1);
			send_item(ACT_LOAD, 6'd61, 6'($urandom), 4'(k), '1);
		end
		send_item(ACT_QUERY, 6'd62, 6'd61, 4'd0, '0);
		send_item(ACT_QUERY, 6'd62, 6'd62, 4'd0, '0);
		send_item(ACT_LOAD, 6'd61, 6'd0, 4'd7, '0);
		send_item(ACT_QUERY, 6'd61, 6'd62, 4'd0, '0);
	endtask

	task automatic test_random_traffic(input int count, input int pool_hi, input int query_pct);
		logic [5:0] a;
		logic [5:0] b;
		for (int n = 0; n < count; n++) begin
			a = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, pool_hi));
			b = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, pool_hi));
			if ($urandom_range(0, 6) == 0)
				b = a;
			if ($urandom_range(1, 100) <= query_pct)
				send_item(ACT_QUERY, a, b, 4'($urandom), {$urandom, $urandom});
			else
				send_item(ACT_LOAD, a, b, 4'($urandom), rand_word());
		end
	endtask

	task automatic test_drain_pause();
		wait_all_scores();
		send_item(ACT_QUERY, 6'd62, 6'd61, 4'd0, '0);
	endtask

	task automatic test_back_to_back(input int count);
		burst_left = count + 1;
		test_random_traffic(count, 5, 45);
		burst_left = 0;
	endtask

	initial begin
		for (int i = 0; i < ITEMS; i++) begin
			vec_ones[i] = '0;
			for (int k = 0; k < WORDS; k++) vec_words[i][k] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_special_cases();
		test_full_vectors();
		test_random_traffic(300, 7, 40);
		test_drain_pause();
		test_random_traffic(220, 63, 35);
		test_back_to_back(150);
		test_random_traffic(150, 3, 50);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_all_scores();
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: jaccard_similarity_engine_top.f
rtl/core/jse_pkg.sv
rtl/core/jse_ram.sv
rtl/core/jse_div.sv
rtl/core/jaccard_similarity_engine_top.sv
dv/jaccard_similarity_engine_top_tb.sv
